[rtl/yuv420_to_rgb_quad_core_macros.svh]
// ----------------------------------------------------------------------------
// yuv420_to_rgb_quad_core assertion macros
// Short forms for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef YUV420_TO_RGB_QUAD_CORE_MACROS_SVH
`define YUV420_TO_RGB_QUAD_CORE_MACROS_SVH

// same-cycle implication
`define YRQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yuv420_to_rgb_quad_core: implication check failed");

// next-cycle implication
`define YRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yuv420_to_rgb_quad_core: next-cycle check failed");

`endif

[rtl/yuv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Constants, codes and helper functions for the BT.601 4:2:0 quad converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yuv2rgb_pkg;

  typedef logic [7:0]         sample_t;
  typedef logic signed [8:0]  offset_t;
  typedef logic signed [19:0] acc_t;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_SLOT0_SOURCE = 2'd1;
  localparam logic [1:0] REG_SLOT1_SOURCE = 2'd2;
  localparam logic [1:0] REG_SLOT2_SOURCE = 2'd3;

  // code zero decodes as i420
  localparam logic [1:0] FMT_ZERO = 2'd0;
  localparam logic [1:0] FMT_I420 = 2'd1;
  localparam logic [1:0] FMT_NV12 = 2'd2;
  localparam logic [1:0] FMT_NV21 = 2'd3;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd3;

  localparam logic [8:0] LUMA_OFFSET   = 9'd16;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;

  localparam acc_t K_Y    = 20'sd298;
  localparam acc_t K_RV   = 20'sd409;
  localparam acc_t K_GU   = 20'sd100;
  localparam acc_t K_GV   = 20'sd208;
  localparam acc_t K_BU   = 20'sd517;
  localparam acc_t Q_HALF = 20'sd128;

  function automatic acc_t widen(input offset_t x);
    widen = {{11{x[8]}}, x};
  endfunction

  // round half up, drop the Q8 fraction, saturate to 0..255
  function automatic sample_t clamp_q8(input acc_t acc);
    acc_t r;
    r = acc + Q_HALF;
    if (r[19]) begin
      clamp_q8 = 8'd0;
    end else if (|r[18:16]) begin
      clamp_q8 = 8'hFF;
    end else begin
      clamp_q8 = r[15:8];
    end
  endfunction

  function automatic sample_t pick_channel(input logic [1:0] src, input sample_t b,
                                           input sample_t g, input sample_t r);
    case (src)
      CH_BLUE:  pick_channel = b;
      CH_GREEN: pick_channel = g;
      CH_RED:   pick_channel = r;
      default:  pick_channel = 8'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/yuv420_to_rgb_quad_core.sv]
// ----------------------------------------------------------------------------
// yuv420_to_rgb_quad_core
// Video-range BT.601 conversion of one 2x2 luma quad with shared chroma to
// four RGB pixel words in a programmable channel order.
// ----------------------------------------------------------------------------
// Accepted quads are registered; pixel words then pass to the result register.
// A quad gives four pixels, one a cycle into the result register unless stalled.
// A new quad is taken in the cycle its last pixel moves to the result register.
// Reset: clears quad and result valid; format i420, slot order blue, green, red.
`default_nettype none

module yuv420_to_rgb_quad_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] luma_top_left,
  input  wire logic [7:0] luma_top_right,
  input  wire logic [7:0] luma_bottom_left,
  input  wire logic [7:0] luma_bottom_right,
  input  wire logic [7:0] chroma_first,
  input  wire logic [7:0] chroma_second,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      slot0_value,
  output logic [7:0]      slot1_value,
  output logic [7:0]      slot2_value,
  output logic [1:0]      pixel_position,
  output logic            last_of_quad
);

  logic [1:0] pixel_format;
  logic [1:0] slot0_source;
  logic [1:0] slot1_source;
  logic [1:0] slot2_source;

  yuv2rgb_pkg::sample_t luma [4];
  yuv2rgb_pkg::offset_t d_off;
  yuv2rgb_pkg::offset_t e_off;
  logic                 quad_valid;
  logic [1:0]           pos;

  logic                 in_accept;
  logic                 out_load;
  logic                 quad_done;
  yuv2rgb_pkg::sample_t u_byte;
  yuv2rgb_pkg::sample_t v_byte;
  yuv2rgb_pkg::offset_t c_off;
  yuv2rgb_pkg::acc_t    yc;
  yuv2rgb_pkg::acc_t    bu;
  yuv2rgb_pkg::acc_t    gu;
  yuv2rgb_pkg::acc_t    gv;
  yuv2rgb_pkg::acc_t    rv;
  yuv2rgb_pkg::sample_t ch_b;
  yuv2rgb_pkg::sample_t ch_g;
  yuv2rgb_pkg::sample_t ch_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= yuv2rgb_pkg::FMT_I420;
      slot0_source <= yuv2rgb_pkg::CH_BLUE;
      slot1_source <= yuv2rgb_pkg::CH_GREEN;
      slot2_source <= yuv2rgb_pkg::CH_RED;
    end else if (cfg_write) begin
      case (cfg_index)
        yuv2rgb_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data;
        yuv2rgb_pkg::REG_SLOT0_SOURCE: slot0_source <= cfg_data;
        yuv2rgb_pkg::REG_SLOT1_SOURCE: slot1_source <= cfg_data;
        yuv2rgb_pkg::REG_SLOT2_SOURCE: slot2_source <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_load  = quad_valid && (!out_valid || !out_stall);
  assign quad_done = out_load && (pos == yuv2rgb_pkg::POS_BOTTOM_RIGHT);
  assign in_stall  = quad_valid && !quad_done;
  assign in_accept = in_valid && !in_stall;

  assign u_byte = (pixel_format == yuv2rgb_pkg::FMT_NV21) ? chroma_second : chroma_first;
  assign v_byte = (pixel_format == yuv2rgb_pkg::FMT_NV21) ? chroma_first : chroma_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
      pos        <= 2'd0;
    end else if (in_accept) begin
      quad_valid <= 1'b1;
      pos        <= 2'd0;
    end else if (out_load) begin
      quad_valid <= !quad_done;
      pos        <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      luma[0] <= luma_top_left;
      luma[1] <= luma_top_right;
      luma[2] <= luma_bottom_left;
      luma[3] <= luma_bottom_right;
      d_off   <= $signed({1'b0, u_byte}) - $signed(yuv2rgb_pkg::CHROMA_OFFSET);
      e_off   <= $signed({1'b0, v_byte}) - $signed(yuv2rgb_pkg::CHROMA_OFFSET);
    end
  end

  assign c_off = $signed({1'b0, luma[pos]}) - $signed(yuv2rgb_pkg::LUMA_OFFSET);
  assign yc    = yuv2rgb_pkg::K_Y  * yuv2rgb_pkg::widen(c_off);
  assign bu    = yuv2rgb_pkg::K_BU * yuv2rgb_pkg::widen(d_off);
  assign gu    = yuv2rgb_pkg::K_GU * yuv2rgb_pkg::widen(d_off);
  assign gv    = yuv2rgb_pkg::K_GV * yuv2rgb_pkg::widen(e_off);
  assign rv    = yuv2rgb_pkg::K_RV * yuv2rgb_pkg::widen(e_off);

  assign ch_b = yuv2rgb_pkg::clamp_q8(yc + bu);
  assign ch_g = yuv2rgb_pkg::clamp_q8(yc - gu - gv);
  assign ch_r = yuv2rgb_pkg::clamp_q8(yc + rv);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot0_value    <= yuv2rgb_pkg::pick_channel(slot0_source, ch_b, ch_g, ch_r);
      slot1_value    <= yuv2rgb_pkg::pick_channel(slot1_source, ch_b, ch_g, ch_r);
      slot2_value    <= yuv2rgb_pkg::pick_channel(slot2_source, ch_b, ch_g, ch_r);
      pixel_position <= pos;
      last_of_quad   <= (pos == yuv2rgb_pkg::POS_BOTTOM_RIGHT);
    end
  end

`include "yuv420_to_rgb_quad_core_macros.svh"

  `YRQ_ASSERT_NEXT(a_accept_starts_quad, clk, rst, in_accept, quad_valid && (pos == 2'd0))
  `YRQ_ASSERT_IMPLY(a_take_only_at_end, clk, rst, quad_valid && !in_stall, quad_done)
  `YRQ_ASSERT_IMPLY(a_last_at_corner, clk, rst, out_valid && last_of_quad,
                    pixel_position == yuv2rgb_pkg::POS_BOTTOM_RIGHT)
  `YRQ_ASSERT_NEXT(a_load_shows_word, clk, rst, out_load, out_valid)

endmodule

`default_nettype wire

[bench/yuv420_to_rgb_quad_core_tb.sv]
// ----------------------------------------------------------------------------
// yuv420_to_rgb_quad_core_tb
// Drives 2x2 luma quads with shared chroma into the converter under several
// format and channel-order settings, predicts the four clamped pixel words of
// each quad and checks every word as it leaves the block. Both handshakes are
// throttled at random in three stretches, the last one without throttling.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_quad_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       drain;
    logic [7:0] chroma_second;
    logic [7:0] chroma_first;
    logic [3:0][7:0] luma;
  } quad_word_t;

  typedef struct packed {
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [1:0] position;
    logic       last;
  } pixel_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] luma_top_left = 8'd0;
  logic [7:0] luma_top_right = 8'd0;
  logic [7:0] luma_bottom_left = 8'd0;
  logic [7:0] luma_bottom_right = 8'd0;
  logic [7:0] chroma_first = 8'd0;
  logic [7:0] chroma_second = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] slot0_value;
  logic [7:0] slot1_value;
  logic [7:0] slot2_value;
  logic [1:0] pixel_position;
  logic       last_of_quad;

  quad_word_t  quads_pending[$];
  pixel_word_t pixels_expected[$];
  quad_word_t  next_quad;
  quad_word_t  seen_quad;
  pixel_word_t got_pixel;
  pixel_word_t want_pixel;

  logic [1:0] fmt_shadow = yuv2rgb_pkg::FMT_I420;
  logic [1:0] slot_src_shadow [3] = '{yuv2rgb_pkg::CH_BLUE, yuv2rgb_pkg::CH_GREEN,
                                      yuv2rgb_pkg::CH_RED};

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  fail_count = 0;
  bit  quad_taken = 1'b0;
  bit  bench_idle = 1'b0;

  yuv420_to_rgb_quad_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .luma_top_left    (luma_top_left),
    .luma_top_right   (luma_top_right),
    .luma_bottom_left (luma_bottom_left),
    .luma_bottom_right(luma_bottom_right),
    .chroma_first     (chroma_first),
    .chroma_second    (chroma_second),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .slot0_value      (slot0_value),
    .slot1_value      (slot1_value),
    .slot2_value      (slot2_value),
    .pixel_position   (pixel_position),
    .last_of_quad     (last_of_quad)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] saturate_q8(input int acc);
    int r;
    r = acc + 128;
    if (r < 0) return 8'd0;
    if ((r >>> 8) > 255) return 8'd255;
    return r[15:8];
  endfunction

  function automatic void predict_pixels(input quad_word_t q);
    int u, v, d, e, yc;
    logic [7:0] chan [3];
    logic [7:0] slot [3];
    pixel_word_t p;
    if (fmt_shadow == yuv2rgb_pkg::FMT_NV21) begin
      v = q.chroma_first;
      u = q.chroma_second;
    end else begin
      u = q.chroma_first;
      v = q.chroma_second;
    end
    d = u - 128;
    e = v - 128;
    for (int k = 0; k < 4; k++) begin
      yc = 298 * (int'(q.luma[k]) - 16);
      chan[yuv2rgb_pkg::CH_BLUE]  = saturate_q8(yc + 517 * d);
      chan[yuv2rgb_pkg::CH_GREEN] = saturate_q8(yc - 100 * d - 208 * e);
      chan[yuv2rgb_pkg::CH_RED]   = saturate_q8(yc + 409 * e);
      for (int s = 0; s < 3; s++) begin
        slot[s] = (slot_src_shadow[s] < yuv2rgb_pkg::CH_NONE) ?
                  chan[slot_src_shadow[s]] : 8'd0;
      end
      p.slot0 = slot[0];
      p.slot1 = slot[1];
      p.slot2 = slot[2];
      p.position = k[1:0];
      p.last = (k[1:0] == yuv2rgb_pkg::POS_BOTTOM_RIGHT);
      pixels_expected.insert(pixels_expected.size(), p);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_pixel = '{slot0_value, slot1_value, slot2_value, pixel_position, last_of_quad};
        if (pixels_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pixel word: s0=%0d s1=%0d s2=%0d pos=%0d last=%0b",
                     got_pixel.slot0, got_pixel.slot1, got_pixel.slot2,
                     got_pixel.position, got_pixel.last);
        end else begin
          want_pixel = pixels_expected.pop_front();
          if (got_pixel !== want_pixel) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: want s0=%0d s1=%0d s2=%0d pos=%0d last=%0b,",
                       want_pixel.slot0, want_pixel.slot1, want_pixel.slot2,
                       want_pixel.position, want_pixel.last,
                       " got s0=%0d s1=%0d s2=%0d pos=%0d last=%0b",
                       got_pixel.slot0, got_pixel.slot1, got_pixel.slot2,
                       got_pixel.position, got_pixel.last);
          end
        end
      end
      quad_taken = in_valid && !in_stall;
      if (quad_taken) begin
        seen_quad.drain = 1'b0;
        seen_quad.chroma_second = chroma_second;
        seen_quad.chroma_first = chroma_first;
        seen_quad.luma[0] = luma_top_left;
        seen_quad.luma[1] = luma_top_right;
        seen_quad.luma[2] = luma_bottom_left;
        seen_quad.luma[3] = luma_bottom_right;
        predict_pixels(seen_quad);
      end
    end else begin
      quad_taken = 1'b0;
    end
    bench_idle = (quads_pending.size() == 0) && (!in_valid || quad_taken) &&
                 (pixels_expected.size() == 0);
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!in_valid || quad_taken) begin
        if (quads_pending.size() != 0 &&
            !(quads_pending[0].drain && pixels_expected.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          next_quad = quads_pending.pop_front();
          in_valid <= 1'b1;
          luma_top_left <= next_quad.luma[0];
          luma_top_right <= next_quad.luma[1];
          luma_bottom_left <= next_quad.luma[2];
          luma_bottom_right <= next_quad.luma[3];
          chroma_first <= next_quad.chroma_first;
          chroma_second <= next_quad.chroma_second;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == yuv2rgb_pkg::REG_PIXEL_FORMAT) fmt_shadow = value;
    else slot_src_shadow[index - 1] = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic [1:0] s0,
                            input logic [1:0] s1, input logic [1:0] s2);
    write_reg(yuv2rgb_pkg::REG_PIXEL_FORMAT, fmt);
    write_reg(yuv2rgb_pkg::REG_SLOT0_SOURCE, s0);
    write_reg(yuv2rgb_pkg::REG_SLOT1_SOURCE, s1);
    write_reg(yuv2rgb_pkg::REG_SLOT2_SOURCE, s2);
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (!bench_idle);
  endtask

  task automatic queue_quad(input logic [7:0] tl, input logic [7:0] tr, input logic [7:0] bl,
                            input logic [7:0] br, input logic [7:0] cf, input logic [7:0] cs,
                            input logic drain);
    quad_word_t q;
    q.drain = drain;
    q.chroma_second = cs;
    q.chroma_first = cf;
    q.luma[0] = tl;
    q.luma[1] = tr;
    q.luma[2] = bl;
    q.luma[3] = br;
    quads_pending.insert(quads_pending.size(), q);
  endtask

  task automatic run_corner_quads;
    queue_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_quad(8'd16, 8'd235, 8'd16, 8'd235, 8'd128, 8'd128, 1'b0);
    queue_quad(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd0, 1'b1);
    queue_quad(8'd200, 8'd50, 8'd128, 8'd16, 8'd0, 8'd255, 1'b0);
    wait_drained();
  endtask

  function automatic logic [7:0] pick_sample();
    logic [7:0] corners [6] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd240};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random_quads(input logic [1:0] fmt, input logic [1:0] s0,
                                  input logic [1:0] s1, input logic [1:0] s2,
                                  input int count);
    int drain_at;
    set_config(fmt, s0, s1, s2);
    drain_at = $urandom_range(1, count - 1);
    for (int n = 0; n < count; n++)
      queue_quad(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), n == drain_at);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 83;

    run_corner_quads();
    set_config(yuv2rgb_pkg::FMT_NV12, yuv2rgb_pkg::CH_RED, yuv2rgb_pkg::CH_GREEN,
               yuv2rgb_pkg::CH_BLUE);
    run_corner_quads();
    set_config(yuv2rgb_pkg::FMT_NV21, yuv2rgb_pkg::CH_BLUE, yuv2rgb_pkg::CH_GREEN,
               yuv2rgb_pkg::CH_RED);
    run_corner_quads();
    set_config(yuv2rgb_pkg::FMT_ZERO, yuv2rgb_pkg::CH_NONE, yuv2rgb_pkg::CH_RED,
               yuv2rgb_pkg::CH_RED);
    run_corner_quads();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 18;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: run_random_quads(yuv2rgb_pkg::FMT_NV12, yuv2rgb_pkg::CH_RED,
                            yuv2rgb_pkg::CH_GREEN, yuv2rgb_pkg::CH_BLUE, 24);
        1: run_random_quads(yuv2rgb_pkg::FMT_NV21, yuv2rgb_pkg::CH_GREEN,
                            yuv2rgb_pkg::CH_BLUE, yuv2rgb_pkg::CH_RED, 24);
        2: run_random_quads(yuv2rgb_pkg::FMT_ZERO, yuv2rgb_pkg::CH_NONE,
                            yuv2rgb_pkg::CH_NONE, yuv2rgb_pkg::CH_NONE, 24);
        3: run_random_quads(yuv2rgb_pkg::FMT_I420, yuv2rgb_pkg::CH_GREEN,
                            yuv2rgb_pkg::CH_GREEN, yuv2rgb_pkg::CH_NONE, 24);
        default: run_random_quads(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 24);
      endcase
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && pixels_expected.size() == 0) begin
      $display("yuv420_to_rgb_quad_core_tb: done, clean");
    end else begin
      $display("yuv420_to_rgb_quad_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("yuv420_to_rgb_quad_core_tb: done, errors");
    $finish;
  end

endmodule
